[design/tvt_pkg.sv]
// Shared types, constants and voltage/temperature curve ROM for the thermistor converter.
package tvt_pkg;

	localparam int TABLE_ENTRIES = 26;
	localparam int ROM_SLOTS     = 64;
	localparam int POINT_COUNT   = (TABLE_ENTRIES > ROM_SLOTS) ? ROM_SLOTS :
		((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);

	localparam int SAMPLE_W = 12;
	localparam int CHAN_W   = 4;
	localparam int TEMP_W   = 18;
	localparam int MV_W     = 12;
	localparam int IDX_W    = $clog2(ROM_SLOTS);
	localparam int DT_W     = TEMP_W + 1;
	localparam int PROD_W   = MV_W + DT_W;
	localparam int CNT_W    = $clog2(DT_W);

	localparam logic [IDX_W-1:0] FIRST_IDX = '0;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POINT_COUNT - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DT_W - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_READFAIL = 2'd2
	} status_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_mv;
		logic                read_failed;
		logic [CHAN_W-1:0]   sensor_channel;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_millic;
		status_t                  status;
		logic [CHAN_W-1:0]        result_channel;
	} result_t;

	// Classified request passed from the search front to the arithmetic back
	typedef struct packed {
		status_t             status;
		logic [CHAN_W-1:0]   chan;
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] smp;
	} entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SEARCH,
		F_HOLD
	} f_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_SUM,
		B_DONE
	} b_state_t;

	// Curve voltage in millivolts, descending; unused slots read as zero
	function automatic logic [MV_W-1:0] rom_mv(input logic [IDX_W-1:0] idx);
		logic [MV_W-1:0] v;
		unique case (idx)
			6'd0:  v = 12'd1619;
			6'd1:  v = 12'd1562;
			6'd2:  v = 12'd1493;
			6'd3:  v = 12'd1413;
			6'd4:  v = 12'd1322;
			6'd5:  v = 12'd1223;
			6'd6:  v = 12'd1117;
			6'd7:  v = 12'd1008;
			6'd8:  v = 12'd900;
			6'd9:  v = 12'd795;
			6'd10: v = 12'd697;
			6'd11: v = 12'd606;
			6'd12: v = 12'd524;
			6'd13: v = 12'd451;
			6'd14: v = 12'd387;
			6'd15: v = 12'd332;
			6'd16: v = 12'd284;
			6'd17: v = 12'd243;
			6'd18: v = 12'd208;
			6'd19: v = 12'd179;
			6'd20: v = 12'd153;
			6'd21: v = 12'd132;
			6'd22: v = 12'd114;
			6'd23: v = 12'd99;
			6'd24: v = 12'd86;
			6'd25: v = 12'd74;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Curve temperature in milli-degrees Celsius, ascending; unused slots read as zero
	function automatic logic signed [TEMP_W-1:0] rom_temp(input logic [IDX_W-1:0] idx);
		logic signed [TEMP_W-1:0] t;
		unique case (idx)
			6'd0:  t = -18'sd15000;
			6'd1:  t = -18'sd10000;
			6'd2:  t = -18'sd5000;
			6'd3:  t = 18'sd0;
			6'd4:  t = 18'sd5000;
			6'd5:  t = 18'sd10000;
			6'd6:  t = 18'sd15000;
			6'd7:  t = 18'sd20000;
			6'd8:  t = 18'sd25000;
			6'd9:  t = 18'sd30000;
			6'd10: t = 18'sd35000;
			6'd11: t = 18'sd40000;
			6'd12: t = 18'sd45000;
			6'd13: t = 18'sd50000;
			6'd14: t = 18'sd55000;
			6'd15: t = 18'sd60000;
			6'd16: t = 18'sd65000;
			6'd17: t = 18'sd70000;
			6'd18: t = 18'sd75000;
			6'd19: t = 18'sd80000;
			6'd20: t = 18'sd85000;
			6'd21: t = 18'sd90000;
			6'd22: t = 18'sd95000;
			6'd23: t = 18'sd100000;
			6'd24: t = 18'sd105000;
			6'd25: t = 18'sd110000;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

[design/thermistor_volt_to_temp_interp_core.sv]
// Top level of the thermistor voltage to temperature converter.
//
// Requests enter on the sample channel (sample_valid / sample_stall / sample) and carry a
// voltage in millivolts, a read-failure flag and a channel tag. Each request yields exactly
// one result on the result channel (result_valid / result_stall / result), in order, with
// the temperature in milli-degrees Celsius, a status code and the echoed channel.
// The front end takes one request at a time and walks the 26-point curve ROM one point
// per cycle to find the segment. A two-entry queue hands classified requests to the back
// end, which multiplies and then divides by the segment span one quotient bit per cycle
// (19 steps). Front and back overlap, so the serial segment search sets the sustained
// throughput at worst. Failed reads and out-of-range samples skip the arithmetic and
// return a zero temperature.
// Reset (arst_n low) empties the queue, idles both halves and drops result_valid.
// While result_stall is high the result holds; the back end then waits, the queue fills,
// and finally sample_stall rises and new requests are held off.
module thermistor_volt_to_temp_interp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  tvt_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output tvt_pkg::result_t result
);
	import tvt_pkg::*;

	logic   push_valid, push_stall;
	logic   pop_valid, pop_stall;
	entry_t push_entry, pop_entry;

	tvt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.push_valid   (push_valid),
		.push_stall   (push_stall),
		.push_entry   (push_entry)
	);

	tvt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_entry  (pop_entry)
	);

	tvt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_stall    (pop_stall),
		.pop_entry    (pop_entry),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[design/tvt_front.sv]
// Request intake: range/failure classification and serial segment search over the curve.
module tvt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_stall,
	input  tvt_pkg::sample_t sample,
	output logic            push_valid,
	input  logic            push_stall,
	output tvt_pkg::entry_t push_entry
);
	import tvt_pkg::*;

	f_state_t            state_q, state_d;
	logic [SAMPLE_W-1:0] smp_q;
	logic                fail_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [IDX_W-1:0]    idx_q;
	status_t             st_q, st_d;
	logic                accept;
	logic                found;

	assign accept       = sample_valid && (state_q == F_IDLE);
	assign sample_stall = (state_q != F_IDLE);
	assign push_valid   = (state_q == F_HOLD);

	assign push_entry.status = st_q;
	assign push_entry.chan   = chan_q;
	assign push_entry.idx    = idx_q;
	assign push_entry.smp    = smp_q;

	// Hold front state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Classify the request, or advance one curve point per cycle
	always_comb begin
		state_d = state_q;
		found   = 1'b0;
		st_d    = ST_OK;
		unique case (state_q)
			F_IDLE: begin
				if (sample_valid) state_d = F_SEARCH;
			end
			F_SEARCH: begin
				found = 1'b1;
				if (fail_q) begin
					st_d = ST_READFAIL;
				end else if (smp_q > rom_mv(FIRST_IDX) || smp_q < rom_mv(LAST_IDX)) begin
					st_d = ST_RANGE;
				end else if (idx_q != LAST_IDX && smp_q < rom_mv(idx_q)) begin
					found = 1'b0;
				end
				if (found) state_d = F_HOLD;
			end
			F_HOLD: begin
				if (!push_stall) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Capture the request and walk the segment index
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q  <= sample.sample_mv;
			fail_q <= sample.read_failed;
			chan_q <= sample.sensor_channel;
			idx_q  <= FIRST_IDX;
		end else if (state_q == F_SEARCH) begin
			if (found) begin
				st_q <= st_d;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

[design/tvt_queue.sv]
// Two-entry queue that decouples the search front from the arithmetic back.
module tvt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_stall,
	input  tvt_pkg::entry_t push_entry,
	output logic            pop_valid,
	input  logic            pop_stall,
	output tvt_pkg::entry_t pop_entry
);
	import tvt_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign push_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_valid && !pop_stall;

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

[design/tvt_back.sv]
// Interpolation back end: multiply, serial restoring divide, offset add and result register.
module tvt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_stall,
	input  tvt_pkg::entry_t pop_entry,
	output logic            result_valid,
	input  logic            result_stall,
	output tvt_pkg::result_t result
);
	import tvt_pkg::*;

	b_state_t                 state_q, state_d;
	status_t                  st_q;
	logic [CHAN_W-1:0]        chan_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic signed [TEMP_W-1:0] base_q;
	logic [MV_W-1:0]          dv_q;
	logic [MV_W-1:0]          span_q;
	logic [DT_W-1:0]          dt_q;
	logic [MV_W-1:0]          rem_q;
	logic [DT_W-1:0]          work_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     res_valid_q;
	result_t                  res_q;

	logic                     take;
	logic                     out_free;
	logic [IDX_W-1:0]         idx_prev;
	logic [PROD_W-1:0]        prod;
	logic [MV_W:0]            rem_sh;
	logic                     q_bit;
	logic [MV_W:0]            rem_diff;

	assign take         = pop_valid && (state_q == B_IDLE);
	assign pop_stall    = (state_q != B_IDLE);
	assign out_free     = !res_valid_q || !result_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign idx_prev     = pop_entry.idx - 1'b1;
	assign prod         = PROD_W'(dv_q) * PROD_W'(dt_q);

	// One restoring divide step: bring down the next dividend bit
	assign rem_sh   = {rem_q, work_q[DT_W-1]};
	assign q_bit    = (rem_sh >= {1'b0, span_q});
	assign rem_diff = rem_sh - {1'b0, span_q};

	// Hold back-end state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence the interpolation steps
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					if (pop_entry.status != ST_OK || pop_entry.idx == FIRST_IDX) begin
						state_d = B_DONE;
					end else begin
						state_d = B_MUL;
					end
				end
			end
			B_MUL:  state_d = B_DIV;
			B_DIV:  if (cnt_q == DIV_LAST) state_d = B_SUM;
			B_SUM:  state_d = B_DONE;
			B_DONE: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (take) begin
					st_q   <= pop_entry.status;
					chan_q <= pop_entry.chan;
					dv_q   <= rom_mv(idx_prev) - pop_entry.smp;
					span_q <= rom_mv(idx_prev) - rom_mv(pop_entry.idx);
					dt_q   <= DT_W'(rom_temp(pop_entry.idx)) - DT_W'(rom_temp(idx_prev));
					base_q <= rom_temp(idx_prev);
					if (pop_entry.status != ST_OK) begin
						temp_q <= '0;
					end else begin
						temp_q <= rom_temp(FIRST_IDX);
					end
				end
			end
			B_MUL: begin
				// The quotient fits DT_W bits, so the upper product bits start below the span
				rem_q  <= prod[PROD_W-1:DT_W];
				work_q <= prod[DT_W-1:0];
				cnt_q  <= '0;
			end
			B_DIV: begin
				rem_q  <= q_bit ? rem_diff[MV_W-1:0] : rem_sh[MV_W-1:0];
				work_q <= {work_q[DT_W-2:0], q_bit};
				cnt_q  <= cnt_q + 1'b1;
			end
			B_SUM: begin
				temp_q <= base_q + $signed(work_q[TEMP_W-1:0]);
			end
			default: begin
			end
		endcase
	end

	// Result register: load when free, drop valid when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == B_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_DONE && out_free) begin
			res_q.temp_millic    <= temp_q;
			res_q.status         <= st_q;
			res_q.result_channel <= chan_q;
		end
	end

endmodule

[design/tvt_checker.sv]
// Port-level checker for the thermistor converter, bound to the top level.
module tvt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_stall,
	input logic             result_valid,
	input logic             result_stall,
	input tvt_pkg::result_t result
);
	import tvt_pkg::*;

	logic [3:0] pend_q;
	logic       req_in, res_out;

	assign req_in  = sample_valid && !sample_stall;
	assign res_out = result_valid && !result_stall;

	// Count requests accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_in && !res_out) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_out && !req_in) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// Every delivered result answers an earlier request
	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_out |-> pend_q != '0)
		else $error("result delivered with no request outstanding");

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Temperature is zero unless the status is ok
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |-> result.temp_millic == '0)
		else $error("nonzero temperature with error status");

	// Interpolated temperature stays within the curve span
	a_temp_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_OK |->
			result.temp_millic >= rom_temp(FIRST_IDX) &&
			result.temp_millic <= rom_temp(LAST_IDX))
		else $error("temperature outside curve span");

endmodule

bind thermistor_volt_to_temp_interp_core tvt_checker u_tvt_checker (.*);
